/* src/nca_pkg.sv */
// nca_pkg: constants, field widths and shared types of the nearest-centroid block.
// No dependencies; all other files import this package.
package nca_pkg;

  // Sizing
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 16;
  localparam int COORD_BITS   = 16;

  localparam int IDX_W   = $clog2(MAX_CLUSTERS);
  localparam int DIM_W   = $clog2(MAX_DIMS);
  localparam int POS_W   = $clog2(MAX_DIMS + 1);
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = 36;

  // Port field widths
  localparam int CLUSTER_W  = 4;
  localparam int DIM_FLD_W  = 4;
  localparam int COORD_W    = 16;
  localparam int NEAREST_W  = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

  // Request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ENABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_CLUSTER  = 2'd2;

  // Centroid coordinate write, broadcast to all cells
  typedef struct packed {
    logic                         we;
    logic [IDX_W-1:0]             cluster;
    logic [DIM_W-1:0]             dim;
    logic signed [COORD_BITS-1:0] coord;
  } load_t;

  // Point datapath control, broadcast to all cells
  typedef struct packed {
    logic                         rd_en;
    logic [DIM_W-1:0]             pos;
    logic signed [COORD_BITS-1:0] coord_a;
    logic                         acc_b;
  } pt_ctl_t;

  // Eligibility settings
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               skip_en;
    logic [IDX_W-1:0]   skip_idx;
  } sel_cfg_t;

  // Running minimum handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  best;
    logic [DIST_W-1:0] min_dist;
  } token_t;

endpackage

/* src/nca_if.sv */
// nca_if: valid/ready channel interfaces for points, results and configuration.
// Depends on nca_pkg.
interface nca_in_if import nca_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [CLUSTER_W-1:0]       cluster;
  logic [DIM_FLD_W-1:0]       dim;
  logic signed [COORD_W-1:0]  coordinate;
  logic                       last;

  modport source (output valid, kind, cluster, dim, coordinate, last, input ready);
  modport sink   (input valid, kind, cluster, dim, coordinate, last, output ready);
endinterface

interface nca_out_if import nca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [NEAREST_W-1:0] nearest;
  logic [DIST_W-1:0]    distance;
  logic                 found;

  modport source (output valid, nearest, distance, found, input ready);
  modport sink   (input valid, nearest, distance, found, output ready);
endinterface

interface nca_cfg_if import nca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/nca_cell.sv */
// nca_cell: one centroid. Holds its coordinates, accumulates the squared
// distance of the current point and updates the passing minimum token. Uses nca_pkg.
module nca_cell import nca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_index,
  input  load_t            ld,
  input  pt_ctl_t          pt,
  input  sel_cfg_t         sel,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic signed [COORD_BITS-1:0] coords [MAX_DIMS];
  logic signed [COORD_BITS-1:0] rd;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [SQ_W-1:0]       sq_full;
  logic [SQ_W-1:0]              sq;
  logic [DIST_W:0]              sum_ext;
  logic [DIST_W-1:0]            sum;
  logic [DIST_W-1:0]            sum_next;
  logic                         eligible;
  logic                         take;

  // Coordinate store, registered read
  always_ff @(posedge clk) begin
    if (ld.we && ld.cluster == cell_index) begin
      coords[ld.dim] <= ld.coord;
    end
    if (pt.rd_en) begin
      rd <= coords[pt.pos];
    end
  end

  // Difference and square, registered
  assign diff    = DIFF_W'(pt.coord_a) - DIFF_W'(rd);
  assign sq_full = diff * diff;

  always_ff @(posedge clk) begin
    sq <= unsigned'(sq_full);
  end

  // Saturating accumulate
  assign sum_ext  = {1'b0, sum} + (DIST_W + 1)'(sq);
  assign sum_next = sum_ext[DIST_W] ? DIST_MAX : sum_ext[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (tok_in.valid) begin
      sum <= '0;            // read out by the token, start over
    end else if (pt.acc_b) begin
      sum <= sum_next;
    end
  end

  // Minimum update; strict compare keeps the lower index on a tie
  assign eligible = (COUNT_W'(cell_index) < sel.count) &&
                    !(sel.skip_en && sel.skip_idx == cell_index);
  assign take     = eligible && (!tok_in.found || sum < tok_in.min_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    if (take) begin
      tok_out.found    <= 1'b1;
      tok_out.best     <= cell_index;
      tok_out.min_dist <= sum;
    end else begin
      tok_out.found    <= tok_in.found;
      tok_out.best     <= tok_in.best;
      tok_out.min_dist <= tok_in.min_dist;
    end
  end

endmodule

/* src/nearest_centroid_assign.sv */
// Nearest-centroid assignment: point coordinates in, closest centroid out.
// Point coordinates and loads are taken one per cycle; after the last coordinate of a
// point, input stalls while a token walks the row of centroid cells, and for longer
// if the previous result has not been taken.
// The result register is loaded when the token leaves the last cell.
// Reset (rst, synchronous) clears sums, position and registers; centroids stay undefined.
module nearest_centroid_assign import nca_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  nca_in_if.sink    item,
  nca_out_if.source result,
  nca_cfg_if.sink   cfg
);

  logic             accept;
  logic             pt_accept;
  logic             busy;
  logic [POS_W-1:0] pos;
  logic             va;
  logic             la;
  logic             vb;
  logic             lb;
  logic             pend;
  logic             launch;
  logic signed [COORD_BITS-1:0] coord_a;
  load_t            ld;
  pt_ctl_t          pt;
  sel_cfg_t         sel;
  token_t           tok [MAX_CLUSTERS+1];

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel.count    <= COUNT_RESET;
      sel.skip_en  <= 1'b0;
      sel.skip_idx <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CLUSTER_COUNT: sel.count    <= cfg.data;
        REG_SKIP_ENABLE:   sel.skip_en  <= cfg.data[0];
        REG_SKIP_CLUSTER:  sel.skip_idx <= IDX_W'(cfg.data);
        default: ;
      endcase
    end
  end

  // Input handshake
  assign item.ready = !busy;
  assign accept     = item.valid && item.ready;
  assign pt_accept  = accept && (item.kind == KIND_POINT);

  // Load broadcast
  assign ld.we      = accept && (item.kind == KIND_LOAD) &&
                      (int'(item.cluster) < MAX_CLUSTERS) && (int'(item.dim) < MAX_DIMS);
  assign ld.cluster = IDX_W'(item.cluster);
  assign ld.dim     = DIM_W'(item.dim);
  assign ld.coord   = COORD_BITS'(item.coordinate);

  // Point pipeline: read, square, accumulate
  assign pt.rd_en   = pt_accept && (int'(pos) < MAX_DIMS);
  assign pt.pos     = pos[DIM_W-1:0];
  assign pt.coord_a = coord_a;
  assign pt.acc_b   = vb;

  always_ff @(posedge clk) begin
    if (pt_accept) begin
      coord_a <= COORD_BITS'(item.coordinate);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      va  <= 1'b0;
      la  <= 1'b0;
      vb  <= 1'b0;
      lb  <= 1'b0;
    end else begin
      va <= pt.rd_en;
      la <= pt_accept && item.last;
      vb <= va;
      lb <= la;
      if (pt_accept) begin
        if (item.last) begin
          pos <= '0;
        end else if (int'(pos) < MAX_DIMS) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  // Search launch waits for an empty result register
  assign launch = pend && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      busy <= 1'b0;
    end else begin
      if (lb) begin
        pend <= 1'b1;
      end else if (launch) begin
        pend <= 1'b0;
      end
      if (pt_accept && item.last) begin
        busy <= 1'b1;
      end else if (tok[MAX_CLUSTERS].valid) begin
        busy <= 1'b0;
      end
    end
  end

  // Row of centroid cells
  assign tok[0].valid    = launch;
  assign tok[0].found    = 1'b0;
  assign tok[0].best     = '0;
  assign tok[0].min_dist = '0;

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
    nca_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .ld         (ld),
      .pt         (pt),
      .sel        (sel),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (tok[MAX_CLUSTERS].valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[MAX_CLUSTERS].valid) begin
      result.found    <= tok[MAX_CLUSTERS].found;
      result.nearest  <= NEAREST_W'(tok[MAX_CLUSTERS].best);
      result.distance <= tok[MAX_CLUSTERS].min_dist;
    end
  end

endmodule

/* src/nca_checker.sv */
// nca_checker: port-level checks of the nearest-centroid block, bound to the top level.
// Depends on nca_pkg and nearest_centroid_assign.
module nca_checker import nca_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_kind,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [NEAREST_W-1:0] out_nearest,
  input logic [DIST_W-1:0]    out_distance,
  input logic                 out_found
);

  // A finished point blocks further requests until its search ends
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_kind == KIND_POINT && in_last) |=> !in_ready)
    else $error("input not stalled after last coordinate");

  // A new result only comes out of a search, while input is stalled
  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a search");

  // No eligible cluster gives an all-zero result
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_nearest == '0 && out_distance == '0))
    else $error("empty result carries data");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_nearest) && $stable(out_distance) && $stable(out_found)))
    else $error("stalled result changed");

endmodule

bind nearest_centroid_assign nca_checker u_nca_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .in_kind      (item.kind),
  .in_last      (item.last),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_nearest  (result.nearest),
  .out_distance (result.distance),
  .out_found    (result.found)
);

/* bench/tb.sv */
// tb: self-checking bench for nearest_centroid_assign (k-means assignment step).
// Predicts each assignment from its own copy of the centroid store and distance sums.
// Depends on nca_pkg and the channel interfaces in nca_if.
module tb;
  import nca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 2 * (MAX_CLUSTERS + 3) + 8;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {SPREAD_WIDE, SPREAD_TIES} spread_t;

  typedef struct packed {
    logic                       kind;
    logic [CLUSTER_W-1:0]       cluster;
    logic [DIM_FLD_W-1:0]       dim;
    logic signed [COORD_W-1:0]  coordinate;
    logic                       last;
  } request_t;

  typedef struct packed {
    logic [NEAREST_W-1:0] nearest;
    logic [DIST_W-1:0]    distance;
    logic                 found;
  } assignment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nca_in_if  request_bus ();
  nca_out_if assign_bus ();
  nca_cfg_if cfg_bus ();

  nearest_centroid_assign i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (request_bus),
    .result (assign_bus),
    .cfg    (cfg_bus)
  );

  // Predicted block state
  logic signed [COORD_W-1:0] centroids [MAX_CLUSTERS][MAX_DIMS];
  logic [DIST_W-1:0]         dist_sums [MAX_CLUSTERS];
  int                        coord_pos = 0;
  logic [COUNT_W-1:0]        pred_count = COUNT_RESET;
  logic                      pred_skip_en = 1'b0;
  logic [IDX_W-1:0]          pred_skip_idx = '0;

  request_t    pending_requests [$];
  assignment_t expected_assignments [$];
  request_t    on_bus;
  assignment_t want;
  int          queued_count = 0;
  int          accepted_count = 0;
  int          failures = 0;
  int          gap_pct = 16;
  int          cycle_count = 0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAIL nearest_centroid_assign");
      $finish;
    end
  end

  // Apply one request: a load updates the predicted store, a coordinate the sums; on last, queue the assignment
  task automatic predict_request(input request_t r);
    int                active;
    longint            diff;
    longint unsigned   sq;
    longint unsigned   total;
    assignment_t       res;
    if (r.kind == KIND_LOAD) begin
      centroids[r.cluster][r.dim] = r.coordinate;
    end else begin
      if (coord_pos < MAX_DIMS) begin
        for (int j = 0; j < MAX_CLUSTERS; j++) begin
          diff = longint'($signed(r.coordinate)) - longint'($signed(centroids[j][coord_pos]));
          sq = longint'(diff * diff);
          if (sq > DIST_MAX) sq = DIST_MAX;
          total = longint'(dist_sums[j]) + sq;
          dist_sums[j] = (total > DIST_MAX) ? DIST_MAX : DIST_W'(total);
        end
        coord_pos++;
      end
      if (r.last) begin
        res = '0;
        active = (pred_count > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(pred_count);
        for (int j = 0; j < active; j++) begin
          if (!(pred_skip_en && j == int'(pred_skip_idx))) begin
            if (!res.found || dist_sums[j] < res.distance) begin
              res.found    = 1'b1;
              res.nearest  = NEAREST_W'(j);
              res.distance = dist_sums[j];
            end
          end
        end
        expected_assignments.insert(expected_assignments.size(), res);
        for (int j = 0; j < MAX_CLUSTERS; j++) dist_sums[j] = '0;
        coord_pos = 0;
      end
    end
  endtask

  // Request driver: holds a request until accepted, idles at random
  always @(posedge clk) begin
    if (rst) begin
      request_bus.valid <= 1'b0;
    end else begin
      if (request_bus.valid && request_bus.ready) begin
        predict_request(on_bus);
        accepted_count++;
      end
      if (!request_bus.valid || request_bus.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
          on_bus = pending_requests.pop_front();
          request_bus.valid      <= 1'b1;
          request_bus.kind       <= on_bus.kind;
          request_bus.cluster    <= on_bus.cluster;
          request_bus.dim        <= on_bus.dim;
          request_bus.coordinate <= on_bus.coordinate;
          request_bus.last       <= on_bus.last;
        end else begin
          request_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each assignment with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      assign_bus.ready <= 1'b0;
    end else begin
      if (assign_bus.valid && assign_bus.ready) begin
        if (expected_assignments.size() == 0) begin
          $display("%0t: unexpected result, expected none, got nearest %0d distance %0d found %0d",
                   $time, assign_bus.nearest, assign_bus.distance, assign_bus.found);
          failures++;
        end else begin
          want = expected_assignments.pop_front();
          if (assign_bus.found !== want.found) begin
            $display("%0t: found expected %0d, got %0d", $time, want.found, assign_bus.found);
            failures++;
          end
          if (assign_bus.nearest !== want.nearest) begin
            $display("%0t: nearest expected %0d, got %0d", $time, want.nearest,
                     assign_bus.nearest);
            failures++;
          end
          if (assign_bus.distance !== want.distance) begin
            $display("%0t: distance expected %0d, got %0d", $time, want.distance,
                     assign_bus.distance);
            failures++;
          end
        end
      end
      assign_bus.ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // Stimulus helpers
  function automatic logic signed [COORD_W-1:0] pick_coord(spread_t spread);
    if (spread == SPREAD_TIES) return COORD_W'(int'($urandom_range(4)) - 2);
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic void push_load(int cl, int dm, logic signed [COORD_W-1:0] value);
    request_t r;
    r.kind       = KIND_LOAD;
    r.cluster    = CLUSTER_W'(cl);
    r.dim        = DIM_FLD_W'(dm);
    r.coordinate = value;
    r.last       = 1'($urandom);
    pending_requests.insert(pending_requests.size(), r);
    queued_count++;
  endfunction

  function automatic void push_coord(logic signed [COORD_W-1:0] value, logic last);
    request_t r;
    r.kind       = KIND_POINT;
    r.cluster    = CLUSTER_W'($urandom);
    r.dim        = DIM_FLD_W'($urandom);
    r.coordinate = value;
    r.last       = last;
    pending_requests.insert(pending_requests.size(), r);
    queued_count++;
  endfunction

  // Point of len coordinates, with an occasional load slipped in mid-point
  function automatic void push_point(spread_t spread, int len);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(11) == 0)
        push_load($urandom_range(15), $urandom_range(15), pick_coord(spread));
      push_coord(pick_coord(spread), i == len - 1);
    end
  endfunction

  // Wait until every request is taken and every assignment checked, then let it settle
  task automatic wait_settled();
    while (accepted_count != queued_count || expected_assignments.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_CLUSTER_COUNT: pred_count    = value;
      REG_SKIP_ENABLE:   pred_skip_en  = value[0];
      REG_SKIP_CLUSTER:  pred_skip_idx = value[IDX_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits of the one-bit and four-bit registers carry random junk
  task automatic set_config(input int count, input logic skip_en, input int skip_idx);
    wait_settled();
    write_reg(REG_CLUSTER_COUNT, CFG_DATA_W'(count));
    write_reg(REG_SKIP_ENABLE, {4'($urandom), skip_en});
    write_reg(REG_SKIP_CLUSTER, {1'($urandom), 4'(skip_idx)});
  endtask

  // One random phase; the sender pauses halfway until all assignments are back
  task automatic run_phase(input int count, input logic skip_en, input int skip_idx,
                           input int gap, input spread_t spread, input int n_items);
    int  start;
    bit  paused;
    int  len;
    set_config(count, skip_en, skip_idx);
    gap_pct = gap;
    paused  = 0;
    if (spread == SPREAD_TIES) begin
      for (int c = 0; c < MAX_CLUSTERS; c++)
        for (int d = 0; d < 4; d++) push_load(c, d, pick_coord(spread));
    end
    start = queued_count;
    while (queued_count - start < n_items) begin
      if (!paused && queued_count - start >= n_items / 2) begin
        wait_settled();
        paused = 1;
      end
      if ($urandom_range(7) == 0) begin
        push_load($urandom_range(15), $urandom_range(15), pick_coord(spread));
      end else begin
        if (spread == SPREAD_TIES) len = $urandom_range(4, 1);
        else if ($urandom_range(9) == 0) len = $urandom_range(20, 17);
        else len = $urandom_range(16, 1);
        push_point(spread, len);
      end
    end
  endtask

  // Sequence
  initial begin
    request_bus.valid      = 1'b0;
    request_bus.kind       = KIND_LOAD;
    request_bus.cluster    = '0;
    request_bus.dim        = '0;
    request_bus.coordinate = '0;
    request_bus.last       = 1'b0;
    assign_bus.ready       = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_CLUSTER_COUNT;
    cfg_bus.data           = '0;
    for (int j = 0; j < MAX_CLUSTERS; j++) dist_sums[j] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole store: cluster 0 at the negative extreme, the rest at the positive one
    for (int c = 0; c < MAX_CLUSTERS; c++)
      for (int d = 0; d < MAX_DIMS; d++) push_load(c, d, (c == 0) ? 16'sh8000 : 16'sh7fff);

    // Reset settings: ties among clusters 1..15 go to the lowest index
    push_coord(16'sd0, 1'b1);
    push_coord(16'sh8000, 1'b1);
    // A load in the middle of a point takes effect for the next coordinate
    push_coord(16'sh7fff, 1'b0);
    push_load(3, 1, 16'sd0);
    push_coord(16'sd0, 1'b1);

    // Single cluster, full-length point at the far extreme plus surplus coordinates
    set_config(1, 1'b0, 0);
    for (int i = 0; i < MAX_DIMS + 2; i++) push_coord(16'sh7fff, i == MAX_DIMS + 1);

    // No cluster in use
    set_config(0, 1'b0, 0);
    push_coord(COORD_W'($urandom), 1'b1);

    // Oversized count acts as full; skipped cluster loses its tie
    set_config(31, 1'b1, 1);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    push_coord(16'sh7fff, 1'b1);

    // Random centroids, then random phases
    for (int c = 0; c < MAX_CLUSTERS; c++)
      for (int d = 0; d < MAX_DIMS; d++) push_load(c, d, pick_coord(SPREAD_WIDE));
    run_phase(16, 1'b0, 0, 16, SPREAD_WIDE, 60);
    run_phase(1, 1'b1, 0, 16, SPREAD_WIDE, 30);
    run_phase(17, 1'b1, 15, 0, SPREAD_WIDE, 100);
    run_phase(16, 1'b0, 0, 16, SPREAD_TIES, 40);
    run_phase($urandom_range(16, 2), 1'($urandom), $urandom_range(15), 16, SPREAD_TIES, 40);
    run_phase(0, 1'b0, 0, 16, SPREAD_WIDE, 20);
    run_phase(31, 1'b1, $urandom_range(15), 16, SPREAD_WIDE, 30);
    run_phase($urandom_range(31), 1'($urandom), $urandom_range(15), 16, SPREAD_TIES, 30);

    wait_settled();
    if (failures == 0) begin
      $display("PASS nearest_centroid_assign");
    end else begin
      $display("FAIL nearest_centroid_assign");
    end
    $finish;
  end

endmodule
